// File: hdl/cle_pkg.sv
// ----------------------------------------------------------------------------
// cle_pkg: shared constants, types and helpers for the console line editor
// Line and history sizes, key codes, result kinds and the controller states.
// ----------------------------------------------------------------------------
package cle_pkg;

  // sizes
  localparam int LINE_MAX   = 64;
  localparam int HIST_DEPTH = 16;

  localparam int LA_W   = $clog2(LINE_MAX);               // line address
  localparam int IDX_W  = $clog2(LINE_MAX + 1);           // length / cursor
  localparam int SLOT_W = $clog2(HIST_DEPTH);             // history slot
  localparam int CNT_W  = $clog2(HIST_DEPTH + 1);         // history count
  localparam int HA_W   = $clog2(HIST_DEPTH * LINE_MAX);  // history text address

  // field widths fixed by the interface
  localparam int KEY_W  = 8;
  localparam int KIND_W = 2;
  localparam int POS_W  = 7;

  // result kinds
  localparam logic [KIND_W-1:0] KIND_STATUS = 2'd0;
  localparam logic [KIND_W-1:0] KIND_BYTE   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_EMPTY  = 2'd2;

  // key codes
  localparam logic [KEY_W-1:0] K_NUL   = 8'd0;
  localparam logic [KEY_W-1:0] K_BS    = 8'd8;
  localparam logic [KEY_W-1:0] K_TAB   = 8'd9;
  localparam logic [KEY_W-1:0] K_LF    = 8'd10;
  localparam logic [KEY_W-1:0] K_FF    = 8'd12;
  localparam logic [KEY_W-1:0] K_CR    = 8'd13;
  localparam logic [KEY_W-1:0] K_NAK   = 8'd21;
  localparam logic [KEY_W-1:0] K_ESC   = 8'd27;
  localparam logic [KEY_W-1:0] K_TILDE = 8'd126;
  localparam logic [KEY_W-1:0] K_DEL   = 8'd127;
  localparam logic [KEY_W-1:0] K_CSI   = 8'd91;
  // codes after ESC [
  localparam logic [KEY_W-1:0] C_UP    = 8'd65;
  localparam logic [KEY_W-1:0] C_DOWN  = 8'd66;
  localparam logic [KEY_W-1:0] C_RIGHT = 8'd67;
  localparam logic [KEY_W-1:0] C_LEFT  = 8'd68;
  localparam logic [KEY_W-1:0] C_HOME1 = 8'd49;
  localparam logic [KEY_W-1:0] C_HOME2 = 8'd72;
  localparam logic [KEY_W-1:0] C_END1  = 8'd52;
  localparam logic [KEY_W-1:0] C_END2  = 8'd70;
  localparam logic [KEY_W-1:0] C_DELC  = 8'd51;

  typedef enum logic [1:0] {
    ESC_NONE,
    ESC_SEEN,
    ESC_CSI
  } esc_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_INS,
    ST_INS_WR,
    ST_RM,
    ST_RM_WR,
    ST_LD,
    ST_LD_WR,
    ST_FIN,
    ST_EM,
    ST_EM_WR
  } state_t;

  // oldest + logical position, wrapped into the slot range
  function automatic logic [SLOT_W-1:0] slot_wrap(input logic [CNT_W:0] sum);
    logic [CNT_W:0] s;
    s = sum;
    if (s >= (CNT_W+1)'(HIST_DEPTH)) s = s - (CNT_W+1)'(HIST_DEPTH);
    return s[SLOT_W-1:0];
  endfunction

  // history text address of byte idx in a slot
  function automatic logic [HA_W-1:0] hist_addr(input logic [SLOT_W-1:0] slot,
                                                input logic [IDX_W-1:0]  idx);
    return HA_W'(slot) * HA_W'(LINE_MAX) + HA_W'(idx[LA_W-1:0]);
  endfunction

endpackage

// File: hdl/cle_ram.sv
// ----------------------------------------------------------------------------
// cle_ram: simple dual-port synchronous RAM
// One write and one read port, read data registered, held when not reading.
// ----------------------------------------------------------------------------
module cle_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: hdl/console_line_editor_with_history_core.sv
// ----------------------------------------------------------------------------
// console_line_editor_with_history_core: line editor with recall history
// Edits one console line from key bytes and emits completed lines.
// ----------------------------------------------------------------------------
// One key is taken at a time. Insert shifts the tail up one byte at a time,
// delete shifts it down the same way, history recall copies an entry byte by
// byte, and a completed line is emitted (and copied into history) byte by
// byte. The longest keys are recalling a full-length entry, which copies
// LINE_MAX bytes and then emits them all, and an insert into a line one
// short of full, which shifts the tail and then emits the completed line.
// Each byte is read and then written, since the line buffer and the history
// text memory each have a single read port. A completed line gives one
// transfer per byte, or one empty-line transfer; every other key gives one
// status transfer. No clearing pass is needed after reset.
module console_line_editor_with_history_core (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_key,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] out_kind,
  output logic [6:0] out_cursor_pos,
  output logic [6:0] out_line_len,
  output logic [7:0] out_line_byte,
  output logic       out_last
);

  localparam int IW = cle_pkg::IDX_W;
  localparam int SW = cle_pkg::SLOT_W;
  localparam int CW = cle_pkg::CNT_W;

  cle_pkg::state_t state_r, state_nxt;
  cle_pkg::esc_t   esc_r, esc_nxt;

  logic [IW-1:0] len_r, len_nxt, cur_r, cur_nxt, idx_r, idx_nxt, ldn_r, ldn_nxt;
  logic [7:0]    key_r, key_nxt;
  logic          done_r, done_nxt;
  logic [SW-1:0] slot_r, slot_nxt, hold_r, hold_nxt;
  logic [CW-1:0] hcnt_r, hcnt_nxt, rp_r, rp_nxt;
  logic [IW-1:0] hlen_r [cle_pkg::HIST_DEPTH];
  logic          hlen_we;

  logic       ov_r, ov_nxt, olast_r, olast_nxt;
  logic [1:0] okind_r, okind_nxt;
  logic [6:0] ocur_r, ocur_nxt, olen_r, olen_nxt;
  logic [7:0] obyte_r, obyte_nxt;
  logic       ofree;

  // memory ports
  logic                        lw_en, lr_en, hw_en, hr_en;
  logic [cle_pkg::LA_W-1:0]    lw_addr, lr_addr;
  logic [7:0]                  lw_data, lr_data, hr_data;
  logic [cle_pkg::HA_W-1:0]    hw_addr, hr_addr;

  logic [CW-1:0] ld_log, rp_dn;
  logic [SW-1:0] ld_slot, app_slot;

  function automatic logic [cle_pkg::LA_W-1:0] LA_SEL(input logic [IW-1:0] v);
    return v[cle_pkg::LA_W-1:0];
  endfunction

  cle_ram #(.DEPTH(cle_pkg::LINE_MAX), .WIDTH(8)) u_line (
    .clk(clk), .we(lw_en), .waddr(lw_addr), .wdata(lw_data),
    .re(lr_en), .raddr(lr_addr), .rdata(lr_data)
  );

  cle_ram #(.DEPTH(cle_pkg::HIST_DEPTH * cle_pkg::LINE_MAX), .WIDTH(8)) u_hist (
    .clk(clk), .we(hw_en), .waddr(hw_addr), .wdata(lr_data),
    .re(hr_en), .raddr(hr_addr), .rdata(hr_data)
  );

  assign in_ready       = (state_r == cle_pkg::ST_IDLE);
  assign out_valid      = ov_r;
  assign out_kind       = okind_r;
  assign out_cursor_pos = ocur_r;
  assign out_line_len   = olen_r;
  assign out_line_byte  = obyte_r;
  assign out_last       = olast_r;
  assign ofree          = !ov_r || out_ready;

  // recall targets and append slot
  assign rp_dn    = (rp_r < hcnt_r) ? rp_r + 1'b1 : rp_r;
  assign ld_log   = (in_key == cle_pkg::C_UP) ? rp_r - 1'b1 : rp_dn;
  assign ld_slot  = cle_pkg::slot_wrap((CW+1)'(hold_r) + (CW+1)'(ld_log));
  assign app_slot = (hcnt_r < CW'(cle_pkg::HIST_DEPTH))
                  ? cle_pkg::slot_wrap((CW+1)'(hold_r) + (CW+1)'(hcnt_r)) : hold_r;

  // next state and datapath control
  always_comb begin
    state_nxt = state_r;  esc_nxt  = esc_r;   len_nxt  = len_r;  cur_nxt = cur_r;
    idx_nxt   = idx_r;    ldn_nxt  = ldn_r;   key_nxt  = key_r;  done_nxt = done_r;
    slot_nxt  = slot_r;   hold_nxt = hold_r;  hcnt_nxt = hcnt_r; rp_nxt  = rp_r;
    hlen_we   = 1'b0;
    ov_nxt    = ov_r && !out_ready;
    okind_nxt = okind_r;  ocur_nxt = ocur_r;  olen_nxt = olen_r;
    obyte_nxt = obyte_r;  olast_nxt = olast_r;
    lw_en = 1'b0; lw_addr = idx_r[cle_pkg::LA_W-1:0]; lw_data = lr_data;
    lr_en = 1'b0; lr_addr = idx_r[cle_pkg::LA_W-1:0];
    hw_en = 1'b0; hw_addr = cle_pkg::hist_addr(slot_r, idx_r);
    hr_en = 1'b0; hr_addr = cle_pkg::hist_addr(slot_r, idx_r);

    unique case (state_r)
      cle_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_nxt = cle_pkg::ST_FIN;
          unique case (esc_r)
            cle_pkg::ESC_SEEN: begin
              esc_nxt = (in_key == cle_pkg::K_CSI) ? cle_pkg::ESC_CSI : cle_pkg::ESC_NONE;
            end
            cle_pkg::ESC_CSI: begin
              esc_nxt = cle_pkg::ESC_NONE;
              unique case (in_key)
                cle_pkg::C_UP: begin
                  if (rp_r != '0) begin
                    rp_nxt    = rp_r - 1'b1;
                    slot_nxt  = ld_slot;
                    ldn_nxt   = hlen_r[ld_slot];
                    idx_nxt   = '0;
                    state_nxt = cle_pkg::ST_LD;
                  end
                end
                cle_pkg::C_DOWN: begin
                  rp_nxt = rp_dn;
                  if (rp_dn >= hcnt_r) begin
                    len_nxt = '0;
                    cur_nxt = '0;
                  end else begin
                    slot_nxt  = ld_slot;
                    ldn_nxt   = hlen_r[ld_slot];
                    idx_nxt   = '0;
                    state_nxt = cle_pkg::ST_LD;
                  end
                end
                cle_pkg::C_RIGHT: if (cur_r < len_r) cur_nxt = cur_r + 1'b1;
                cle_pkg::C_LEFT:  if (cur_r != '0) cur_nxt = cur_r - 1'b1;
                cle_pkg::C_HOME1, cle_pkg::C_HOME2: cur_nxt = '0;
                cle_pkg::C_END1, cle_pkg::C_END2:   cur_nxt = len_r;
                cle_pkg::C_DELC: begin
                  if (len_r > cur_r) begin
                    idx_nxt   = cur_r;
                    state_nxt = cle_pkg::ST_RM;
                  end
                end
                default: ;
              endcase
            end
            default: begin
              esc_nxt = cle_pkg::ESC_NONE;
              unique case (in_key)
                cle_pkg::K_NUL, cle_pkg::K_LF, cle_pkg::K_CR: done_nxt = 1'b1;
                cle_pkg::K_NAK: begin
                  len_nxt = '0;
                  cur_nxt = '0;
                end
                cle_pkg::K_BS, cle_pkg::K_DEL: begin
                  if (cur_r != '0) begin
                    cur_nxt   = cur_r - 1'b1;
                    idx_nxt   = cur_r - 1'b1;
                    state_nxt = cle_pkg::ST_RM;
                  end
                end
                cle_pkg::K_ESC: esc_nxt = cle_pkg::ESC_SEEN;
                cle_pkg::K_TAB, cle_pkg::K_FF, cle_pkg::K_TILDE: ;
                default: begin
                  if (len_r < IW'(cle_pkg::LINE_MAX)) begin
                    key_nxt   = in_key;
                    idx_nxt   = len_r;
                    state_nxt = cle_pkg::ST_INS;
                  end
                end
              endcase
            end
          endcase
        end
      end

      // insert: move tail up one byte, then drop the key in
      cle_pkg::ST_INS: begin
        if (idx_r > cur_r) begin
          lr_en     = 1'b1;
          lr_addr   = LA_SEL(idx_r - 1'b1);
          state_nxt = cle_pkg::ST_INS_WR;
        end else begin
          lw_en     = 1'b1;
          lw_addr   = cur_r[cle_pkg::LA_W-1:0];
          lw_data   = key_r;
          cur_nxt   = cur_r + 1'b1;
          len_nxt   = len_r + 1'b1;
          state_nxt = cle_pkg::ST_FIN;
        end
      end
      cle_pkg::ST_INS_WR: begin
        lw_en     = 1'b1;
        idx_nxt   = idx_r - 1'b1;
        state_nxt = cle_pkg::ST_INS;
      end

      // remove: move tail down one byte
      cle_pkg::ST_RM: begin
        if (idx_r + 1'b1 < len_r) begin
          lr_en     = 1'b1;
          lr_addr   = LA_SEL(idx_r + 1'b1);
          state_nxt = cle_pkg::ST_RM_WR;
        end else begin
          len_nxt   = len_r - 1'b1;
          state_nxt = cle_pkg::ST_FIN;
        end
      end
      cle_pkg::ST_RM_WR: begin
        lw_en     = 1'b1;
        idx_nxt   = idx_r + 1'b1;
        state_nxt = cle_pkg::ST_RM;
      end

      // recall: copy history entry into the line buffer
      cle_pkg::ST_LD: begin
        if (idx_r < ldn_r) begin
          hr_en     = 1'b1;
          state_nxt = cle_pkg::ST_LD_WR;
        end else begin
          len_nxt   = ldn_r;
          cur_nxt   = ldn_r;
          state_nxt = cle_pkg::ST_FIN;
        end
      end
      cle_pkg::ST_LD_WR: begin
        lw_en     = 1'b1;
        lw_data   = hr_data;
        idx_nxt   = idx_r + 1'b1;
        state_nxt = cle_pkg::ST_LD;
      end

      // report status or start completion
      cle_pkg::ST_FIN: begin
        if (done_r || len_r == IW'(cle_pkg::LINE_MAX)) begin
          if (len_r == '0) begin
            if (ofree) begin
              ov_nxt = 1'b1; okind_nxt = cle_pkg::KIND_EMPTY;
              ocur_nxt = '0; olen_nxt = '0; obyte_nxt = '0; olast_nxt = 1'b1;
              done_nxt = 1'b0; rp_nxt = hcnt_r; state_nxt = cle_pkg::ST_IDLE;
            end
          end else begin
            done_nxt = 1'b0;
            slot_nxt = app_slot;
            hlen_we  = 1'b1;
            if (hcnt_r < CW'(cle_pkg::HIST_DEPTH)) begin
              hcnt_nxt = hcnt_r + 1'b1;
            end else begin
              hold_nxt = cle_pkg::slot_wrap((CW+1)'(hold_r) + (CW+1)'(1));
            end
            idx_nxt   = '0;
            state_nxt = cle_pkg::ST_EM;
          end
        end else if (ofree) begin
          ov_nxt = 1'b1; okind_nxt = cle_pkg::KIND_STATUS;
          ocur_nxt = cle_pkg::POS_W'(cur_r); olen_nxt = cle_pkg::POS_W'(len_r);
          obyte_nxt = '0; olast_nxt = 1'b1;
          state_nxt = cle_pkg::ST_IDLE;
        end
      end

      // emit: read a byte, present it and copy it into history
      cle_pkg::ST_EM: begin
        lr_en     = 1'b1;
        state_nxt = cle_pkg::ST_EM_WR;
      end
      cle_pkg::ST_EM_WR: begin
        if (ofree) begin
          ov_nxt = 1'b1; okind_nxt = cle_pkg::KIND_BYTE;
          ocur_nxt = '0; olen_nxt = '0; obyte_nxt = lr_data;
          olast_nxt = (idx_r + 1'b1 == len_r);
          hw_en   = 1'b1;
          idx_nxt = idx_r + 1'b1;
          if (idx_r + 1'b1 == len_r) begin
            len_nxt   = '0;
            cur_nxt   = '0;
            rp_nxt    = hcnt_r;
            state_nxt = cle_pkg::ST_IDLE;
          end else begin
            state_nxt = cle_pkg::ST_EM;
          end
        end
      end
      default: state_nxt = cle_pkg::ST_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= cle_pkg::ST_IDLE;
      esc_r   <= cle_pkg::ESC_NONE;
      len_r   <= '0;
      cur_r   <= '0;
      done_r  <= 1'b0;
      hcnt_r  <= '0;
      hold_r  <= '0;
      rp_r    <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      esc_r   <= esc_nxt;
      len_r   <= len_nxt;
      cur_r   <= cur_nxt;
      done_r  <= done_nxt;
      hcnt_r  <= hcnt_nxt;
      hold_r  <= hold_nxt;
      rp_r    <= rp_nxt;
      ov_r    <= ov_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    idx_r   <= idx_nxt;
    ldn_r   <= ldn_nxt;
    key_r   <= key_nxt;
    slot_r  <= slot_nxt;
    okind_r <= okind_nxt;
    ocur_r  <= ocur_nxt;
    olen_r  <= olen_nxt;
    obyte_r <= obyte_nxt;
    olast_r <= olast_nxt;
    if (hlen_we) begin
      hlen_r[app_slot] <= len_r;
    end
  end

`ifndef SYNTHESIS
  a_cur_in_line: assert property (@(posedge clk) disable iff (!rst_n)
    cur_r <= len_r) else $error("cursor beyond line end");
  a_len_max: assert property (@(posedge clk) disable iff (!rst_n)
    len_r <= IW'(cle_pkg::LINE_MAX)) else $error("line longer than buffer");
  a_recall_range: assert property (@(posedge clk) disable iff (!rst_n)
    rp_r <= hcnt_r) else $error("recall position past history");
  a_hist_count: assert property (@(posedge clk) disable iff (!rst_n)
    hcnt_r <= CW'(cle_pkg::HIST_DEPTH)) else $error("history count overflow");
  a_byte_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == cle_pkg::ST_EM_WR && ofree && idx_r + 1'b1 == len_r)
      |=> (state_r == cle_pkg::ST_IDLE && len_r == '0 && rp_r == hcnt_r))
    else $error("line not cleared after last byte");
`endif

endmodule

// File: verif/cle_checker.sv
// ----------------------------------------------------------------------------
// cle_checker: result checker for the console line editor
// Watches key and result transfers, predicts each key's results and compares.
// ----------------------------------------------------------------------------
module cle_checker (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_ready,
  input  logic [7:0] in_key,
  input  logic       out_valid,
  input  logic       out_ready,
  input  logic [1:0] out_kind,
  input  logic [6:0] out_cursor_pos,
  input  logic [6:0] out_line_len,
  input  logic [7:0] out_line_byte,
  input  logic       out_last,
  output int         fail_count,
  output int         pending,
  output int         lines_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [1:0] kind;
    logic [6:0] cursor_pos;
    logic [6:0] line_len;
    logic [7:0] line_byte;
    logic       last;
  } ed_result_t;

  ed_result_t  want_q[$];

  // predictor copy of the editor state
  logic [7:0]     line_buf[cle_pkg::LINE_MAX];
  int             line_n;
  int             cur;
  cle_pkg::esc_t  esc;
  logic [7:0]     hist_buf[cle_pkg::HIST_DEPTH][cle_pkg::LINE_MAX];
  int             hist_len[cle_pkg::HIST_DEPTH];
  int             hist_cnt;
  int             hist_old;
  int             recall;

  function automatic void recall_entry(int logical);
    int slot;
    slot = (hist_old + logical) % cle_pkg::HIST_DEPTH;
    for (int i = 0; i < hist_len[slot]; i++) line_buf[i] = hist_buf[slot][i];
    line_n = hist_len[slot];
    cur = line_n;
  endfunction

  function automatic void drop_at(int pos);
    for (int i = pos; i + 1 < line_n; i++) line_buf[i] = line_buf[i + 1];
    line_n--;
  endfunction

  // apply one key and queue its expected results
  function automatic void edit_key(logic [7:0] k);
    bit         done;
    int         slot;
    ed_result_t r;
    done = 0;
    if (esc == cle_pkg::ESC_SEEN) begin
      esc = (k == cle_pkg::K_CSI) ? cle_pkg::ESC_CSI : cle_pkg::ESC_NONE;
    end else if (esc == cle_pkg::ESC_CSI) begin
      esc = cle_pkg::ESC_NONE;
      case (k)
        cle_pkg::C_UP: if (recall > 0) begin
          recall--;
          recall_entry(recall);
        end
        cle_pkg::C_DOWN: begin
          if (recall < hist_cnt) recall++;
          if (recall >= hist_cnt) begin
            line_n = 0;
            cur = 0;
          end else recall_entry(recall);
        end
        cle_pkg::C_RIGHT: if (cur < line_n) cur++;
        cle_pkg::C_LEFT:  if (cur > 0) cur--;
        cle_pkg::C_HOME1, cle_pkg::C_HOME2: cur = 0;
        cle_pkg::C_END1, cle_pkg::C_END2:   cur = line_n;
        cle_pkg::C_DELC: if (line_n > cur) drop_at(cur);
        default: ;
      endcase
    end else begin
      case (k)
        cle_pkg::K_NUL, cle_pkg::K_LF, cle_pkg::K_CR: done = 1;
        cle_pkg::K_NAK: begin
          line_n = 0;
          cur = 0;
        end
        cle_pkg::K_BS, cle_pkg::K_DEL: if (cur > 0) begin
          cur--;
          drop_at(cur);
        end
        cle_pkg::K_ESC: esc = cle_pkg::ESC_SEEN;
        cle_pkg::K_TAB, cle_pkg::K_FF, cle_pkg::K_TILDE: ;
        default: if (line_n < cle_pkg::LINE_MAX) begin
          for (int i = line_n; i > cur; i--) line_buf[i] = line_buf[i - 1];
          line_buf[cur] = k;
          cur++;
          line_n++;
        end
      endcase
    end
    if (line_n >= cle_pkg::LINE_MAX) done = 1;

    if (!done) begin
      r = '{cle_pkg::KIND_STATUS, 7'(cur), 7'(line_n), 8'd0, 1'b1};
      want_q.push_back(r);
      return;
    end
    lines_seen++;
    if (line_n == 0) begin
      want_q.push_back('{cle_pkg::KIND_EMPTY, 7'd0, 7'd0, 8'd0, 1'b1});
    end else begin
      if (hist_cnt < cle_pkg::HIST_DEPTH) begin
        slot = (hist_old + hist_cnt) % cle_pkg::HIST_DEPTH;
        hist_cnt++;
      end else begin
        slot = hist_old;
        hist_old = (hist_old + 1) % cle_pkg::HIST_DEPTH;
      end
      for (int i = 0; i < line_n; i++) begin
        hist_buf[slot][i] = line_buf[i];
        r = '{cle_pkg::KIND_BYTE, 7'd0, 7'd0, line_buf[i], 1'(i == line_n - 1)};
        want_q.push_back(r);
      end
      hist_len[slot] = line_n;
    end
    line_n = 0;
    cur = 0;
    recall = hist_cnt;
  endfunction

  always @(posedge clk) begin
    ed_result_t w;
    if (!rst_n) begin
      line_n = 0;
      cur = 0;
      esc = cle_pkg::ESC_NONE;
      hist_cnt = 0;
      hist_old = 0;
      recall = 0;
      fail_count = 0;
      lines_seen = 0;
      want_q.delete();
    end else begin
      // result transfer first: a key taken this edge cannot answer yet
      if (out_valid && out_ready) begin
        if (want_q.size() == 0) begin
          $error("unexpected result kind=%0d byte=%0d", out_kind, out_line_byte);
          fail_count++;
        end else begin
          w = want_q.pop_front();
          if (out_kind !== w.kind) begin
            $error("kind: expected %0d got %0d", w.kind, out_kind);
            fail_count++;
          end
          if (out_cursor_pos !== w.cursor_pos) begin
            $error("cursor_pos: expected %0d got %0d", w.cursor_pos, out_cursor_pos);
            fail_count++;
          end
          if (out_line_len !== w.line_len) begin
            $error("line_len: expected %0d got %0d", w.line_len, out_line_len);
            fail_count++;
          end
          if (out_line_byte !== w.line_byte) begin
            $error("line_byte: expected %0d got %0d", w.line_byte, out_line_byte);
            fail_count++;
          end
          if (out_last !== w.last) begin
            $error("last: expected %0d got %0d", w.last, out_last);
            fail_count++;
          end
        end
      end
      if (in_valid && in_ready) edit_key(in_key);
    end
    pending = want_q.size();
  end
endmodule

// File: verif/tb_console_line_editor_with_history_core.sv
// ----------------------------------------------------------------------------
// tb_console_line_editor_with_history_core: testbench for the line editor
// Directed and random key streams with random gaps and stalls on both sides;
// a checker beside the block predicts and compares every result transfer.
// ----------------------------------------------------------------------------
module tb_console_line_editor_with_history_core;
  timeunit 1ns;
  timeprecision 1ps;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_ready;
  logic [7:0] in_key;
  logic       out_valid;
  logic       out_ready;
  logic [1:0] out_kind;
  logic [6:0] out_cursor_pos;
  logic [6:0] out_line_len;
  logic [7:0] out_line_byte;
  logic       out_last;
  int         fail_count;
  int         pending;
  int         lines_seen;
  int         keys_sent;
  bit         hold_off;
  bit         stim_done;

  console_line_editor_with_history_core dut (.*);

  cle_checker chk (.*);

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  // one key transfer, with a random gap first; valid stays up for a
  // back-to-back key
  task automatic send_key(logic [7:0] k);
    int gap;
    gap = $urandom_range(0, 5);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_key   <= k;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    keys_sent++;
    @(negedge clk);
  endtask

  // drop valid before a pause in the stimulus
  task automatic stop_input();
    in_valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic send_csi(logic [7:0] code);
    send_key(cle_pkg::K_ESC);
    send_key(cle_pkg::K_CSI);
    send_key(code);
  endtask

  task automatic send_text(int n);
    for (int i = 0; i < n; i++) send_key(8'($urandom_range(32, 125)));
  endtask

  // random key weighted towards real editing
  task automatic random_key();
    int   sel;
    logic [7:0] codes[10];
    codes = '{cle_pkg::C_UP, cle_pkg::C_DOWN, cle_pkg::C_RIGHT, cle_pkg::C_LEFT,
              cle_pkg::C_HOME1, cle_pkg::C_HOME2, cle_pkg::C_END1, cle_pkg::C_END2,
              cle_pkg::C_DELC, 8'($urandom_range(0, 255))};
    sel = $urandom_range(0, 99);
    if (sel < 45)      send_key(8'($urandom_range(32, 125)));
    else if (sel < 70) send_csi(codes[$urandom_range(0, 9)]);
    else if (sel < 78) send_key($urandom_range(0, 1) ? cle_pkg::K_BS : cle_pkg::K_DEL);
    else if (sel < 84) send_key($urandom_range(0, 1) ? cle_pkg::K_CR : cle_pkg::K_LF);
    else if (sel < 86) send_key(cle_pkg::K_NAK);
    else if (sel < 90) begin
      send_key(cle_pkg::K_ESC);
      send_key(8'($urandom_range(0, 255)));
    end else           send_key(8'($urandom_range(0, 255)));
  endtask

  // receiver: random wait per transfer, plus one long hold-off on request
  initial begin
    int gap;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off) begin
        out_ready <= 1'b0;
        repeat (400) @(negedge clk);
        hold_off = 0;
      end else begin
        gap = $urandom_range(0, 5);
        if (gap != 0) begin
          out_ready <= 1'b0;
          repeat (gap) @(negedge clk);
        end
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  initial begin
    #3000000;
    $display("tb: failure");
    $finish;
  end

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_key = '0;
    keys_sent = 0;
    hold_off = 0;
    stim_done = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: empty line, no-op keys, edits at the limits, unknown CSI
    send_key(cle_pkg::K_NUL);
    send_key(cle_pkg::K_TAB); send_key(cle_pkg::K_FF); send_key(cle_pkg::K_TILDE);
    send_key(cle_pkg::K_BS); send_csi(cle_pkg::C_LEFT); send_csi(cle_pkg::C_RIGHT);
    send_csi(cle_pkg::C_DELC);
    send_csi(cle_pkg::C_UP); send_csi(cle_pkg::C_DOWN);
    send_key(8'hff); send_key(8'h80); send_key(8'h01);
    send_csi(cle_pkg::C_HOME1); send_csi(cle_pkg::C_DELC); send_key(cle_pkg::K_DEL);
    send_csi(cle_pkg::C_END2);
    send_csi(8'd99); send_key(cle_pkg::K_ESC); send_key(cle_pkg::K_NUL);
    send_key(cle_pkg::K_NAK); send_text(3); send_key(cle_pkg::K_LF);

    // fill to the limit, which completes the line, then recall it:
    // the recalled full entry completes at once
    send_text(cle_pkg::LINE_MAX);
    send_csi(cle_pkg::C_UP);
    send_text(5); send_csi(cle_pkg::C_HOME2); send_text(2); send_key(cle_pkg::K_CR);
    send_csi(cle_pkg::C_UP); send_csi(cle_pkg::C_UP);
    send_csi(cle_pkg::C_DOWN); send_csi(cle_pkg::C_DOWN);
    send_key(cle_pkg::K_CR);

    // long receiver stall while keys keep coming
    hold_off = 1;
    send_text(8);
    send_key(cle_pkg::K_CR);
    send_text(4);
    // wait for the queue to drain before going on
    stop_input();
    while (pending != 0) @(negedge clk);

    // random: lines of edits
    for (int i = 0; i < 25; i++) random_key();
    // short lines, enough to wrap the history
    for (int j = 0; j < 18; j++) begin
      send_text($urandom_range(1, 3));
      if ($urandom_range(0, 1)) send_csi(cle_pkg::C_UP);
      send_key(cle_pkg::K_CR);
    end
    stim_done = 1;
    stop_input();

    while (pending != 0) @(negedge clk);
    repeat (300) @(negedge clk);
    $display("run: %0d keys sent, %0d lines completed, history wrapped with recall",
             keys_sent, lines_seen);
    if (fail_count == 0 && pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule

// File: console_line_editor_with_history_core.f
hdl/cle_pkg.sv
hdl/cle_ram.sv
hdl/console_line_editor_with_history_core.sv
verif/cle_checker.sv
verif/tb_console_line_editor_with_history_core.sv
